@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file smsp_checker.
// Depends on nothing; the user supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/core/smsp_pkg.sv @@
// Types, codes and small tables for the stack map section parser.
// No dependencies.
package smsp_pkg;

	localparam logic [1:0] KIND_ROOT = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_OK   = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [7:0] REG_BIG_ENDIAN = 8'd0;
	localparam logic [7:0] REG_STACK_REG  = 8'd1;
	localparam logic [7:0] REG_PTR_BYTES  = 8'd2;
	localparam logic [7:0] REG_TARGET_OK  = 8'd3;

	localparam logic [4:0] E_SIZE        = 5'd0;
	localparam logic [4:0] E_HDR_TRUNC   = 5'd1;
	localparam logic [4:0] E_HDR_BAD     = 5'd2;
	localparam logic [4:0] E_LIMIT       = 5'd3;
	localparam logic [4:0] E_FN_TRUNC    = 5'd4;
	localparam logic [4:0] E_FN_RECS     = 5'd5;
	localparam logic [4:0] E_CONST       = 5'd6;
	localparam logic [4:0] E_TARGET      = 5'd7;
	localparam logic [4:0] E_REC_TRUNC   = 5'd8;
	localparam logic [4:0] E_REC_BAD     = 5'd9;
	localparam logic [4:0] E_PC_OVF      = 5'd10;
	localparam logic [4:0] E_LOC_TRUNC   = 5'd11;
	localparam logic [4:0] E_LOC_RES     = 5'd12;
	localparam logic [4:0] E_ROOT_REG    = 5'd13;
	localparam logic [4:0] E_ROOT_RANGE  = 5'd14;
	localparam logic [4:0] E_ROOT_KIND   = 5'd15;
	localparam logic [4:0] E_LOC_KIND    = 5'd16;
	localparam logic [4:0] E_PAD_TRUNC   = 5'd17;
	localparam logic [4:0] E_LIVE_OUT    = 5'd18;
	localparam logic [4:0] E_REC_COUNT   = 5'd19;

	localparam int SIZE_LIMIT  = 16 * 1024 * 1024;
	localparam int FUNC_LIMIT  = 65536;
	localparam int COUNT_LIMIT = 1048576;
	localparam int LOC_LIMIT   = 32768;
	localparam int FRAME_SLACK = 4096;

	localparam logic [4:0] PH_PREFIX = 5'd0;
	localparam logic [4:0] PH_FCOUNT = 5'd1;
	localparam logic [4:0] PH_CCOUNT = 5'd2;
	localparam logic [4:0] PH_RCOUNT = 5'd3;
	localparam logic [4:0] PH_FADDR  = 5'd4;
	localparam logic [4:0] PH_FSTACK = 5'd5;
	localparam logic [4:0] PH_FRECS  = 5'd6;
	localparam logic [4:0] PH_CSKIP  = 5'd7;
	localparam logic [4:0] PH_RID    = 5'd8;
	localparam logic [4:0] PH_ROFF   = 5'd9;
	localparam logic [4:0] PH_RRES   = 5'd10;
	localparam logic [4:0] PH_RCNT   = 5'd11;
	localparam logic [4:0] PH_LKIND  = 5'd12;
	localparam logic [4:0] PH_LRES8  = 5'd13;
	localparam logic [4:0] PH_LSIZE  = 5'd14;
	localparam logic [4:0] PH_LREG   = 5'd15;
	localparam logic [4:0] PH_LRES16 = 5'd16;
	localparam logic [4:0] PH_LOFF   = 5'd17;
	localparam logic [4:0] PH_PAD1   = 5'd18;
	localparam logic [4:0] PH_LOPAD  = 5'd19;
	localparam logic [4:0] PH_LOCNT  = 5'd20;
	localparam logic [4:0] PH_LOSKIP = 5'd21;
	localparam logic [4:0] PH_PAD2   = 5'd22;
	localparam logic [4:0] PH_DONE   = 5'd23;
	localparam logic [4:0] PH_HALT   = 5'd24;
	localparam logic [4:0] PH_SEEK   = 5'd25;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] pc;
		logic [31:0] offset;
		logic [4:0]  err;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        big_endian;
		logic [15:0] stack_reg;
		logic [3:0]  ptr_bytes;
		logic        target_ok;
		logic [63:0] pc_limit;
	} cfg_t;

	function automatic logic [3:0] field_width(input logic [4:0] ph);
		logic [3:0] w;
		unique case (ph)
			PH_PREFIX, PH_FCOUNT, PH_CCOUNT, PH_RCOUNT, PH_ROFF, PH_LOFF: w = 4'd4;
			PH_FADDR, PH_FSTACK, PH_FRECS, PH_RID: w = 4'd8;
			PH_RRES, PH_RCNT, PH_LSIZE, PH_LREG, PH_LRES16, PH_LOPAD, PH_LOCNT: w = 4'd2;
			PH_LKIND, PH_LRES8: w = 4'd1;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic [4:0] trunc_code(input logic [4:0] ph);
		logic [4:0] c;
		unique case (ph)
			PH_PREFIX, PH_FCOUNT, PH_CCOUNT, PH_RCOUNT: c = E_HDR_TRUNC;
			PH_FADDR, PH_FSTACK, PH_FRECS: c = E_FN_TRUNC;
			PH_CSKIP: c = E_CONST;
			PH_RID, PH_ROFF, PH_RRES, PH_RCNT: c = E_REC_TRUNC;
			PH_LKIND, PH_LRES8, PH_LSIZE, PH_LREG, PH_LRES16, PH_LOFF: c = E_LOC_TRUNC;
			PH_PAD1: c = E_PAD_TRUNC;
			PH_LOPAD, PH_LOCNT, PH_LOSKIP, PH_PAD2: c = E_LIVE_OUT;
			default: c = E_REC_COUNT;
		endcase
		return c;
	endfunction

	function automatic result_t make_err(input logic [4:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.err = code;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

@@ rtl/core/smsp_in_fifo.sv @@
// Front queue: two-entry byte queue between the input port and the parser.
// Depends on smsp_pkg.
module smsp_in_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  smsp_pkg::in_item_t push_item,
	output logic               ready,
	output logic               valid,
	output smsp_pkg::in_item_t item,
	input  logic               pop
);
	smsp_pkg::in_item_t buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign ready = (cnt_q != 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign item  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && ready) begin
			buf_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && ready) begin
				wp_q <= ~wp_q;
			end
			if (pop && valid) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push && ready} - {1'b0, pop && valid};
		end
	end
endmodule

@@ rtl/core/smsp_parser.sv @@
// Back part: byte-serial parse of the section, function tables in memory.
// Depends on smsp_pkg.
module smsp_parser #(
	parameter int MAX_FUNCTIONS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smsp_pkg::cfg_t     cfg,
	input  logic               in_valid,
	input  smsp_pkg::in_item_t in_item,
	output logic               in_pop,
	input  logic               out_room,
	output logic [1:0]         res_count,
	output smsp_pkg::result_t  res0,
	output smsp_pkg::result_t  res1
);
	localparam int IW = (MAX_FUNCTIONS > 1) ? $clog2(MAX_FUNCTIONS) : 1;

	logic [63:0] addr_mem  [MAX_FUNCTIONS];
	logic [63:0] frame_mem [MAX_FUNCTIONS];
	logic [20:0] recs_mem  [MAX_FUNCTIONS];
	logic [63:0] rd_addr, rd_frame;
	logic [20:0] rd_recs;

	logic [4:0]  phase_q, ph;
	logic [24:0] offset_q, offs;
	logic [63:0] shift_q, sh;
	logic [3:0]  fbi_q, fbi;
	logic [16:0] ftot_q, ftot, fcur_q, fcur;
	logic [20:0] ctot_q, ctot, rtot_q, rtot, rsum_q, rsum;
	logic [20:0] rcur_q, rcur, rdone_q, rdone;
	logic [15:0] locleft_q, locleft;
	logic [48:0] lf_q, lf;
	logic [23:0] skip_q, skip;
	logic [63:0] pc_q, pc;
	logic [63:0] caddr_q, caddr, cframe_q, cframe;
	logic [20:0] crecs_q, crecs;
	logic        primed_q, primed, pend_q, pend;
	logic        we_a, we_f, we_r;
	logic [63:0] wv;
	logic        e_v, l_v, do_last;
	smsp_pkg::result_t e, l;

	always_ff @(posedge clk) begin
		if (we_a) addr_mem[fcur_q[IW-1:0]] <= wv;
		if (we_f) frame_mem[fcur_q[IW-1:0]] <= wv;
		if (we_r) recs_mem[fcur_q[IW-1:0]] <= wv[20:0];
		rd_addr  <= addr_mem[fcur_q[IW-1:0]];
		rd_frame <= frame_mem[fcur_q[IW-1:0]];
		rd_recs  <= recs_mem[fcur_q[IW-1:0]];
	end

	always_comb begin
		logic [7:0]  b;
		logic [3:0]  w;
		logic [63:0] v, off64;
		logic [31:0] raw;
		logic [32:0] negmag, bound;
		logic        ptr;
		ph = phase_q; offs = offset_q; sh = shift_q; fbi = fbi_q;
		ftot = ftot_q; ctot = ctot_q; rtot = rtot_q; rsum = rsum_q;
		fcur = fcur_q; rcur = rcur_q; rdone = rdone_q; locleft = locleft_q;
		lf = lf_q; skip = skip_q; pc = pc_q;
		caddr = caddr_q; cframe = cframe_q; crecs = crecs_q;
		primed = primed_q; pend = pend_q;
		we_a = 1'b0; we_f = 1'b0; we_r = 1'b0; wv = '0;
		e_v = 1'b0; e = '0; l_v = 1'b0; l = '0; do_last = 1'b0; in_pop = 1'b0;
		b = in_item.data; w = '0; v = '0; off64 = '0; raw = '0;
		negmag = '0; bound = '0; ptr = 1'b0;
		if (phase_q == smsp_pkg::PH_SEEK) begin
			if (!primed_q) begin
				primed = 1'b1;
			end else begin
				primed = 1'b0;
				if (fcur_q >= ftot_q) begin
					ph = smsp_pkg::PH_DONE;
				end else if (rd_recs == 21'd0) begin
					fcur = fcur_q + 17'd1;
				end else begin
					ph = smsp_pkg::PH_RID;
					caddr = rd_addr; cframe = rd_frame; crecs = rd_recs;
				end
				if (ph != smsp_pkg::PH_SEEK && pend_q) begin
					pend = 1'b0;
					do_last = 1'b1;
				end
			end
		end else if (in_valid && out_room) begin
			in_pop = 1'b1;
			if (phase_q == smsp_pkg::PH_HALT) begin
				// dropped
			end else if (offset_q >= 25'(smsp_pkg::SIZE_LIMIT)) begin
				e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_SIZE);
				ph = smsp_pkg::PH_HALT;
			end else begin
				offs = offset_q + 25'd1;
				w = smsp_pkg::field_width(ph);
				if (ph == smsp_pkg::PH_CSKIP || ph == smsp_pkg::PH_LOSKIP) begin
					if (skip != 24'd0) skip = skip - 24'd1;
				end else if (w != 4'd0) begin
					if (ph == smsp_pkg::PH_PREFIX) begin
						if (fbi == 4'd0) lf = '0;
						if (b != ((fbi == 4'd0) ? 8'd3 : 8'd0)) lf[0] = 1'b1;
					end
					if (fbi == 4'd0) sh = '0;
					if (cfg.big_endian) sh = {sh[55:0], b};
					else sh[{fbi[2:0], 3'b000} +: 8] = b;
					fbi = fbi + 4'd1;
					if (fbi >= w) begin
						v = sh; fbi = '0; sh = '0;
						unique case (ph)
							smsp_pkg::PH_PREFIX: ph = smsp_pkg::PH_FCOUNT;
							smsp_pkg::PH_FCOUNT: begin
								ftot = (v > 64'(smsp_pkg::FUNC_LIMIT)) ?
									17'(smsp_pkg::FUNC_LIMIT + 1) : v[16:0];
								ph = smsp_pkg::PH_CCOUNT;
							end
							smsp_pkg::PH_CCOUNT: begin
								ctot = (v > 64'(smsp_pkg::COUNT_LIMIT)) ?
									21'(smsp_pkg::COUNT_LIMIT + 1) : v[20:0];
								ph = smsp_pkg::PH_RCOUNT;
							end
							smsp_pkg::PH_RCOUNT: begin
								rtot = (v > 64'(smsp_pkg::COUNT_LIMIT)) ?
									21'(smsp_pkg::COUNT_LIMIT + 1) : v[20:0];
								if (lf[0]) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_HDR_BAD);
									ph = smsp_pkg::PH_HALT;
								end else if (ftot > 17'(smsp_pkg::FUNC_LIMIT) ||
									ftot > 17'(MAX_FUNCTIONS) ||
									rtot > 21'(smsp_pkg::COUNT_LIMIT) ||
									ctot > 21'(smsp_pkg::COUNT_LIMIT)) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_LIMIT);
									ph = smsp_pkg::PH_HALT;
								end else begin
									fcur = '0; rsum = '0;
									if (ftot == 17'd0) begin
										if (rtot != 21'd0) begin
											e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_CONST);
											ph = smsp_pkg::PH_HALT;
										end else begin
											skip = {ctot, 3'b000};
											ph = smsp_pkg::PH_CSKIP;
										end
									end else begin
										ph = smsp_pkg::PH_FADDR;
									end
								end
							end
							smsp_pkg::PH_FADDR: begin
								we_a = (fcur_q < 17'(MAX_FUNCTIONS)); wv = v;
								ph = smsp_pkg::PH_FSTACK;
							end
							smsp_pkg::PH_FSTACK: begin
								we_f = (fcur_q < 17'(MAX_FUNCTIONS)); wv = v;
								ph = smsp_pkg::PH_FRECS;
							end
							smsp_pkg::PH_FRECS: begin
								if (v > {43'd0, rtot} || rsum > rtot - v[20:0]) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_FN_RECS);
									ph = smsp_pkg::PH_HALT;
								end else begin
									rsum = rsum + v[20:0];
									we_r = (fcur_q < 17'(MAX_FUNCTIONS)); wv = v;
									fcur = fcur_q + 17'd1;
									if (fcur >= ftot) begin
										if (rsum != rtot) begin
											e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_CONST);
											ph = smsp_pkg::PH_HALT;
										end else begin
											skip = {ctot, 3'b000};
											ph = smsp_pkg::PH_CSKIP;
										end
									end else begin
										ph = smsp_pkg::PH_FADDR;
									end
								end
							end
							smsp_pkg::PH_RID: ph = smsp_pkg::PH_ROFF;
							smsp_pkg::PH_ROFF: begin
								lf = {17'd0, v[31:0]};
								ph = smsp_pkg::PH_RRES;
							end
							smsp_pkg::PH_RRES: begin
								if (v != 64'd0) lf[32] = 1'b1;
								ph = smsp_pkg::PH_RCNT;
							end
							smsp_pkg::PH_RCNT: begin
								off64 = {32'd0, lf[31:0]};
								if (lf[32] || v > 64'(smsp_pkg::LOC_LIMIT)) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_REC_BAD);
									ph = smsp_pkg::PH_HALT;
								end else if (off64 > cfg.pc_limit ||
									caddr_q > cfg.pc_limit - off64) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_PC_OVF);
									ph = smsp_pkg::PH_HALT;
								end else begin
									pc = caddr_q + off64;
									locleft = v[15:0];
									ph = smsp_pkg::PH_LKIND;
								end
							end
							smsp_pkg::PH_LKIND: begin
								lf = {41'd0, v[7:0]};
								ph = smsp_pkg::PH_LRES8;
							end
							smsp_pkg::PH_LRES8: begin
								if (v != 64'd0) lf[8] = 1'b1;
								ph = smsp_pkg::PH_LSIZE;
							end
							smsp_pkg::PH_LSIZE: begin
								lf[31:16] = v[15:0];
								ph = smsp_pkg::PH_LREG;
							end
							smsp_pkg::PH_LREG: begin
								lf[47:32] = v[15:0];
								ph = smsp_pkg::PH_LRES16;
							end
							smsp_pkg::PH_LRES16: begin
								if (v != 64'd0) lf[48] = 1'b1;
								ph = smsp_pkg::PH_LOFF;
							end
							smsp_pkg::PH_LOFF: begin
								raw = v[31:0];
								ptr = (lf[31:16] == {12'd0, cfg.ptr_bytes});
								negmag = 33'd0 - {raw[31], raw};
								bound = {1'b0, cframe_q[31:0]} + 33'(smsp_pkg::FRAME_SLACK);
								if (lf[8] || lf[48]) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_LOC_RES);
								end else if (lf[7:0] == 8'd3 && ptr) begin
									if (lf[47:32] != cfg.stack_reg) begin
										e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_ROOT_REG);
									end else if ((!raw[31] &&
										raw > 32'(smsp_pkg::FRAME_SLACK)) ||
										(raw[31] && cframe_q[63:32] == 32'd0 &&
										negmag > bound)) begin
										e_v = 1'b1;
										e = smsp_pkg::make_err(smsp_pkg::E_ROOT_RANGE);
									end else begin
										e_v = 1'b1;
										e.kind = smsp_pkg::KIND_ROOT;
										e.pc = pc_q;
										e.offset = raw;
									end
								end else if ((lf[7:0] == 8'd1 || lf[7:0] == 8'd2) && ptr) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_ROOT_KIND);
								end else if (lf[7:0] < 8'd1 || lf[7:0] > 8'd5) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_LOC_KIND);
								end
								if (e_v && e.kind == smsp_pkg::KIND_ERR) begin
									ph = smsp_pkg::PH_HALT;
								end else begin
									locleft = locleft - 16'd1;
									ph = smsp_pkg::PH_LKIND;
								end
							end
							smsp_pkg::PH_LOPAD: begin
								if (v != 64'd0) begin
									e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_LIVE_OUT);
									ph = smsp_pkg::PH_HALT;
								end else begin
									ph = smsp_pkg::PH_LOCNT;
								end
							end
							smsp_pkg::PH_LOCNT: begin
								skip = {6'd0, v[15:0], 2'b00};
								ph = smsp_pkg::PH_LOSKIP;
							end
							default: ;
						endcase
					end
				end
				// settle
				if (ph == smsp_pkg::PH_CSKIP && skip == 24'd0) begin
					if (!cfg.target_ok) begin
						e_v = 1'b1; e = smsp_pkg::make_err(smsp_pkg::E_TARGET);
						ph = smsp_pkg::PH_HALT;
					end else begin
						fcur = '0; rcur = '0; rdone = '0;
						ph = smsp_pkg::PH_SEEK; primed = 1'b0;
					end
				end
				if (ph == smsp_pkg::PH_LKIND && locleft == 16'd0) ph = smsp_pkg::PH_PAD1;
				if (ph == smsp_pkg::PH_PAD1 && offs[2:0] == 3'd0) ph = smsp_pkg::PH_LOPAD;
				if (ph == smsp_pkg::PH_LOSKIP && skip == 24'd0) ph = smsp_pkg::PH_PAD2;
				if (ph == smsp_pkg::PH_PAD2 && offs[2:0] == 3'd0) begin
					e_v = 1'b1;
					e = '0;
					e.kind = smsp_pkg::KIND_END;
					e.pc = pc;
					rdone = rdone + 21'd1;
					rcur = rcur + 21'd1;
					if (rcur >= crecs_q) begin
						fcur = fcur + 17'd1;
						rcur = '0;
						ph = smsp_pkg::PH_SEEK; primed = 1'b0;
					end else begin
						ph = smsp_pkg::PH_RID;
					end
				end
				do_last = in_item.last;
			end
		end
		if (do_last && ph != smsp_pkg::PH_HALT) begin
			if (ph == smsp_pkg::PH_SEEK) begin
				pend = 1'b1;
			end else if (ph == smsp_pkg::PH_DONE) begin
				l_v = 1'b1;
				if (rdone != rtot) begin
					l = smsp_pkg::make_err(smsp_pkg::E_REC_COUNT);
				end else begin
					l = '0;
					l.kind = smsp_pkg::KIND_OK;
					l.last = 1'b1;
				end
				ph = smsp_pkg::PH_HALT;
			end else begin
				l_v = 1'b1;
				l = smsp_pkg::make_err(smsp_pkg::trunc_code(ph));
				ph = smsp_pkg::PH_HALT;
			end
		end
		res0 = e_v ? e : l;
		res1 = l;
		res_count = {1'b0, e_v} + {1'b0, l_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= smsp_pkg::PH_PREFIX;
			offset_q <= '0; shift_q <= '0; fbi_q <= '0;
			ftot_q <= '0; ctot_q <= '0; rtot_q <= '0; rsum_q <= '0;
			fcur_q <= '0; rcur_q <= '0; rdone_q <= '0; locleft_q <= '0;
			lf_q <= '0; skip_q <= '0; pc_q <= '0;
			caddr_q <= '0; cframe_q <= '0; crecs_q <= '0;
			primed_q <= 1'b0; pend_q <= 1'b0;
		end else begin
			phase_q <= ph;
			offset_q <= offs; shift_q <= sh; fbi_q <= fbi;
			ftot_q <= ftot; ctot_q <= ctot; rtot_q <= rtot; rsum_q <= rsum;
			fcur_q <= fcur; rcur_q <= rcur; rdone_q <= rdone; locleft_q <= locleft;
			lf_q <= lf; skip_q <= skip; pc_q <= pc;
			caddr_q <= caddr; cframe_q <= cframe; crecs_q <= crecs;
			primed_q <= primed; pend_q <= pend;
		end
	end
endmodule

@@ rtl/core/smsp_out_fifo.sv @@
// Result queue: four entries, up to two pushed per cycle, one popped.
// Depends on smsp_pkg.
module smsp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_count,
	input  smsp_pkg::result_t d0,
	input  smsp_pkg::result_t d1,
	output logic              room,
	output logic              valid,
	output smsp_pkg::result_t item,
	input  logic              ready
);
	smsp_pkg::result_t buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign room  = (cnt_q <= 3'd2);
	assign valid = (cnt_q != 3'd0);
	assign item  = buf_q[rp_q];
	assign pop   = valid && ready;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) buf_q[wp_q] <= d0;
		if (push_count == 2'd2) buf_q[wp_q + 2'd1] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push_count;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_count} - {2'b00, pop};
		end
	end
endmodule

@@ rtl/core/stack_map_section_parser.sv @@
// Stack map section parser: bytes in, roots, record ends and a final status out.
// A two-entry byte queue feeds the parser; a four-entry queue holds
// results. Throughput is one byte per cycle while the result queue has room;
// entering the record area and each move to the next function pause intake while
// function-table entries are scanned (registered read). No clearing pass.
// Depends on smsp_pkg, smsp_in_fifo, smsp_parser, smsp_out_fifo.
module stack_map_section_parser #(
	parameter int MAX_FUNCTIONS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic         s_tlast,  // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // record pc, stack_offset, error_code, zero fill
	output logic [1:0]   m_tuser,  // result_kind
	output logic         m_tlast,  // last_result
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	smsp_pkg::cfg_t     cfg_q;
	smsp_pkg::in_item_t in_item, q_item;
	smsp_pkg::result_t  res0, res1, out_item;
	logic        q_valid, pop, room;
	logic [1:0]  res_count;
	logic [63:0] lim;

	assign cfg_ready = 1'b1;
	assign in_item.data = s_tdata;
	assign in_item.last = s_tlast;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lim[8*i +: 8] = (4'(i) < cfg_data[3:0]) ? 8'hff : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_endian <= 1'b0;
			cfg_q.stack_reg  <= 16'd7;
			cfg_q.ptr_bytes  <= 4'd8;
			cfg_q.target_ok  <= 1'b1;
			cfg_q.pc_limit   <= '1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				smsp_pkg::REG_BIG_ENDIAN: cfg_q.big_endian <= cfg_data[0];
				smsp_pkg::REG_STACK_REG:  cfg_q.stack_reg <= cfg_data;
				smsp_pkg::REG_PTR_BYTES: begin
					cfg_q.ptr_bytes <= cfg_data[3:0];
					cfg_q.pc_limit  <= lim;
				end
				smsp_pkg::REG_TARGET_OK:  cfg_q.target_ok <= cfg_data[0];
				default: ;
			endcase
		end
	end

	smsp_in_fifo u_front (
		.clk(clk), .arst_n(arst_n),
		.push(s_tvalid), .push_item(in_item), .ready(s_tready),
		.valid(q_valid), .item(q_item), .pop(pop)
	);

	smsp_parser #(.MAX_FUNCTIONS(MAX_FUNCTIONS)) u_parse (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(q_valid), .in_item(q_item), .in_pop(pop),
		.out_room(room), .res_count(res_count), .res0(res0), .res1(res1)
	);

	smsp_out_fifo u_back (
		.clk(clk), .arst_n(arst_n),
		.push_count(res_count), .d0(res0), .d1(res1), .room(room),
		.valid(m_tvalid), .item(out_item), .ready(m_tready)
	);

	assign m_tdata = {3'b000, out_item.err, out_item.offset, out_item.pc};
	assign m_tuser = out_item.kind;
	assign m_tlast = out_item.last;
endmodule

@@ rtl/core/smsp_checker.sv @@
// Port-level checks on the result stream of the stack map section parser.
// Depends on smsp_pkg and assert_macros.svh; bound to the top level.
`include "assert_macros.svh"
module smsp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata,
	input logic [1:0]   m_tuser,
	input logic         m_tlast
);
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_nothing_after_end, clk, arst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)
	`ASSERT_IMPLIES(a_last_kind, clk, arst_n, m_tvalid, m_tlast == (m_tuser == smsp_pkg::KIND_OK || m_tuser == smsp_pkg::KIND_ERR))
	`ASSERT_IMPLIES(a_code_clear, clk, arst_n, m_tvalid && m_tuser != smsp_pkg::KIND_ERR, m_tdata[100:96] == 5'd0)
endmodule

bind stack_map_section_parser smsp_checker u_chk (.*);

@@ dv/smsp_result_checker.sv @@
// Result checker for the stack map section parser: predicts results from the
// accepted bytes and register writes, and compares them with the output stream.
// Depends on smsp_pkg.
module smsp_result_checker
	import smsp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [7:0]   s_tdata,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam int FN_DEPTH = 1024;

	result_t predicted_results[$];

	logic        be;
	logic [15:0] sreg;
	logic [3:0]  pbytes;
	logic        tgt;

	logic [4:0]  phase;
	int unsigned boff, fidx;
	logic [63:0] fshift, loc_f, cur_pc;
	int unsigned fn_total, const_total, rec_total, rec_summed;
	logic [63:0] fn_addr  [FN_DEPTH];
	logic [63:0] fn_frame [FN_DEPTH];
	int unsigned fn_recs  [FN_DEPTH];
	int unsigned fn_cur, rec_cur, rec_done, locs_left, skip_left;
	bit          failed;
	int          step_results;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic int unsigned width_of(input logic [4:0] ph);
		case (ph)
			PH_PREFIX, PH_FCOUNT, PH_CCOUNT, PH_RCOUNT, PH_ROFF, PH_LOFF: return 4;
			PH_FADDR, PH_FSTACK, PH_FRECS, PH_RID: return 8;
			PH_RRES, PH_RCNT, PH_LSIZE, PH_LREG, PH_LRES16, PH_LOPAD, PH_LOCNT: return 2;
			PH_LKIND, PH_LRES8: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic logic [4:0] cut_short_code(input logic [4:0] ph);
		case (ph)
			PH_PREFIX, PH_FCOUNT, PH_CCOUNT, PH_RCOUNT: return E_HDR_TRUNC;
			PH_FADDR, PH_FSTACK, PH_FRECS: return E_FN_TRUNC;
			PH_CSKIP: return E_CONST;
			PH_RID, PH_ROFF, PH_RRES, PH_RCNT: return E_REC_TRUNC;
			PH_LKIND, PH_LRES8, PH_LSIZE, PH_LREG, PH_LRES16, PH_LOFF: return E_LOC_TRUNC;
			PH_PAD1: return E_PAD_TRUNC;
			PH_LOPAD, PH_LOCNT, PH_LOSKIP, PH_PAD2: return E_LIVE_OUT;
			default: return E_REC_COUNT;
		endcase
	endfunction

	function automatic logic [63:0] pc_ceiling();
		if (pbytes >= 4'd8) return '1;
		return (64'd1 << (8 * pbytes)) - 64'd1;
	endfunction

	function automatic int unsigned recs_of(input int unsigned i);
		return i < FN_DEPTH ? fn_recs[i] : 0;
	endfunction

	task automatic emit(input logic [1:0] kind, input logic [63:0] pc, input logic [31:0] off,
			input logic [4:0] code, input logic lst);
		result_t r;
		r.kind = kind;
		r.pc = pc;
		r.offset = off;
		r.err = code;
		r.last = lst;
		if (step_results < 2) predicted_results.insert(predicted_results.size(), r);
		step_results++;
	endtask

	task automatic abort_parse(input logic [4:0] code);
		emit(KIND_ERR, '0, '0, code, 1'b1);
		failed = 1;
		phase = PH_HALT;
	endtask

	task automatic next_record();
		while (fn_cur < fn_total && recs_of(fn_cur) == 0) fn_cur++;
		phase = fn_cur < fn_total ? PH_RID : PH_DONE;
	endtask

	task automatic close_fn_table();
		if (rec_summed != rec_total) begin
			abort_parse(E_CONST);
		end else begin
			skip_left = const_total * 8;
			phase = PH_CSKIP;
		end
	endtask

	task automatic check_location(input logic [63:0] v);
		logic [7:0]  kind;
		logic [15:0] size, regn;
		logic [31:0] raw;
		longint      off;
		logic [63:0] frame;
		bit          ptr;
		kind = loc_f[7:0];
		size = loc_f[31:16];
		regn = loc_f[47:32];
		raw = v[31:0];
		off = longint'($signed(raw));
		ptr = size == {12'd0, pbytes};
		frame = fn_cur < FN_DEPTH ? fn_frame[fn_cur] : '0;
		if (loc_f[8] || loc_f[48]) begin
			abort_parse(E_LOC_RES);
		end else if (kind == 8'd3 && ptr) begin
			if (regn != sreg)
				abort_parse(E_ROOT_REG);
			else if (off > FRAME_SLACK)
				abort_parse(E_ROOT_RANGE);
			else if (off < 0 && frame <= 64'hFFFF_FFFF_FFFF_EFFF &&
					64'(-off) > frame + 64'(FRAME_SLACK))
				abort_parse(E_ROOT_RANGE);
			else
				emit(KIND_ROOT, cur_pc, raw, '0, 1'b0);
		end else if ((kind == 8'd1 || kind == 8'd2) && ptr) begin
			abort_parse(E_ROOT_KIND);
		end else if (kind < 8'd1 || kind > 8'd5) begin
			abort_parse(E_LOC_KIND);
		end
	endtask

	task automatic field_done(input logic [63:0] v);
		int unsigned fc;
		logic [63:0] lim, addr, off;
		fc = fn_cur;
		case (phase)
			PH_PREFIX: phase = PH_FCOUNT;
			PH_FCOUNT: begin
				fn_total = v > FUNC_LIMIT ? FUNC_LIMIT + 1 : v[31:0];
				phase = PH_CCOUNT;
			end
			PH_CCOUNT: begin
				const_total = v > COUNT_LIMIT ? COUNT_LIMIT + 1 : v[31:0];
				phase = PH_RCOUNT;
			end
			PH_RCOUNT: begin
				rec_total = v > COUNT_LIMIT ? COUNT_LIMIT + 1 : v[31:0];
				if (loc_f[0]) begin
					abort_parse(E_HDR_BAD);
				end else if (fn_total > FUNC_LIMIT || fn_total > FN_DEPTH ||
						rec_total > COUNT_LIMIT || const_total > COUNT_LIMIT) begin
					abort_parse(E_LIMIT);
				end else begin
					fn_cur = 0;
					rec_summed = 0;
					if (fn_total == 0) close_fn_table();
					else phase = PH_FADDR;
				end
			end
			PH_FADDR: begin
				if (fc < FN_DEPTH) fn_addr[fc] = v;
				phase = PH_FSTACK;
			end
			PH_FSTACK: begin
				if (fc < FN_DEPTH) fn_frame[fc] = v;
				phase = PH_FRECS;
			end
			PH_FRECS: begin
				if (v > rec_total || rec_summed > rec_total - v[31:0]) begin
					abort_parse(E_FN_RECS);
				end else begin
					rec_summed += v[31:0];
					if (fc < FN_DEPTH) fn_recs[fc] = v[31:0];
					fn_cur = fc + 1;
					if (fn_cur >= fn_total) close_fn_table();
					else phase = PH_FADDR;
				end
			end
			PH_RID: phase = PH_ROFF;
			PH_ROFF: begin
				loc_f = {32'd0, v[31:0]};
				phase = PH_RRES;
			end
			PH_RRES: begin
				if (v != 0) loc_f[32] = 1'b1;
				phase = PH_RCNT;
			end
			PH_RCNT: begin
				off = {32'd0, loc_f[31:0]};
				addr = fc < FN_DEPTH ? fn_addr[fc] : '0;
				lim = pc_ceiling();
				if (loc_f[32] || v > LOC_LIMIT) begin
					abort_parse(E_REC_BAD);
				end else if (off > lim || addr > lim - off) begin
					abort_parse(E_PC_OVF);
				end else begin
					cur_pc = addr + off;
					locs_left = v[15:0];
					phase = PH_LKIND;
				end
			end
			PH_LKIND: begin
				loc_f = {56'd0, v[7:0]};
				phase = PH_LRES8;
			end
			PH_LRES8: begin
				if (v != 0) loc_f[8] = 1'b1;
				phase = PH_LSIZE;
			end
			PH_LSIZE: begin
				loc_f[31:16] = v[15:0];
				phase = PH_LREG;
			end
			PH_LREG: begin
				loc_f[47:32] = v[15:0];
				phase = PH_LRES16;
			end
			PH_LRES16: begin
				if (v != 0) loc_f[48] = 1'b1;
				phase = PH_LOFF;
			end
			PH_LOFF: begin
				check_location(v);
				if (!failed) begin
					locs_left = (locs_left - 1) & 32'hFFFF;
					phase = PH_LKIND;
				end
			end
			PH_LOPAD: begin
				if (v != 0) abort_parse(E_LIVE_OUT);
				else phase = PH_LOCNT;
			end
			PH_LOCNT: begin
				skip_left = v[15:0] * 4;
				phase = PH_LOSKIP;
			end
			default: ;
		endcase
	endtask

	task automatic settle();
		bit go;
		go = 1;
		while (go && !failed) begin
			case (phase)
				PH_CSKIP: begin
					if (skip_left != 0) begin
						go = 0;
					end else if (!tgt) begin
						abort_parse(E_TARGET);
					end else begin
						fn_cur = 0;
						rec_cur = 0;
						rec_done = 0;
						next_record();
					end
				end
				PH_LKIND: begin
					if (locs_left != 0) go = 0;
					else phase = PH_PAD1;
				end
				PH_PAD1: begin
					if (boff % 8 != 0) go = 0;
					else phase = PH_LOPAD;
				end
				PH_LOSKIP: begin
					if (skip_left != 0) go = 0;
					else phase = PH_PAD2;
				end
				PH_PAD2: begin
					if (boff % 8 != 0) begin
						go = 0;
					end else begin
						emit(KIND_END, cur_pc, '0, '0, 1'b0);
						rec_done++;
						rec_cur++;
						if (rec_cur >= recs_of(fn_cur)) begin
							fn_cur++;
							rec_cur = 0;
						end
						next_record();
					end
				end
				default: go = 0;
			endcase
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst);
		int unsigned w;
		logic [63:0] v;
		step_results = 0;
		if (failed || phase >= PH_HALT) return;
		if (boff >= SIZE_LIMIT) begin
			abort_parse(E_SIZE);
			return;
		end
		boff = (boff + 1) & 32'h1FF_FFFF;
		w = width_of(phase);
		if (phase == PH_CSKIP || phase == PH_LOSKIP) begin
			if (skip_left != 0) skip_left--;
		end else if (w != 0) begin
			if (phase == PH_PREFIX) begin
				if (fidx == 0) loc_f = '0;
				if (b != (fidx == 0 ? 8'd3 : 8'd0)) loc_f[0] = 1'b1;
			end
			if (fidx == 0) fshift = '0;
			if (be) fshift = {fshift[55:0], b};
			else fshift = fshift | (64'(b) << (8 * (fidx % 8)));
			fidx++;
			if (fidx >= w) begin
				v = fshift;
				fidx = 0;
				fshift = '0;
				field_done(v);
			end
		end
		settle();
		if (!failed && lst) begin
			if (phase == PH_DONE) begin
				if (rec_done != rec_total) begin
					abort_parse(E_REC_COUNT);
				end else begin
					emit(KIND_OK, '0, '0, '0, 1'b1);
					phase = PH_HALT;
				end
			end else begin
				abort_parse(cut_short_code(phase));
			end
		end
	endtask

	task automatic check_result();
		result_t exp_r;
		if (predicted_results.size() == 0) begin
			$error("result with nothing expected: kind %0d pc %h", m_tuser, m_tdata[63:0]);
			fail_count++;
			return;
		end
		exp_r = predicted_results.pop_front();
		if (m_tuser !== exp_r.kind) begin
			$error("result_kind expected %0d actual %0d", exp_r.kind, m_tuser);
			fail_count++;
		end
		if (m_tdata[63:0] !== exp_r.pc) begin
			$error("record pc expected %h actual %h", exp_r.pc, m_tdata[63:0]);
			fail_count++;
		end
		if (m_tdata[95:64] !== exp_r.offset) begin
			$error("stack_offset expected %h actual %h", exp_r.offset, m_tdata[95:64]);
			fail_count++;
		end
		if (m_tdata[100:96] !== exp_r.err) begin
			$error("error_code expected %0d actual %0d", exp_r.err, m_tdata[100:96]);
			fail_count++;
		end
		if (m_tlast !== exp_r.last) begin
			$error("last_result expected %0d actual %0d", exp_r.last, m_tlast);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			be = 1'b0;
			sreg = 16'd7;
			pbytes = 4'd8;
			tgt = 1'b1;
			phase = PH_PREFIX;
			boff = 0;
			fidx = 0;
			fshift = '0;
			loc_f = '0;
			cur_pc = '0;
			fn_total = 0;
			const_total = 0;
			rec_total = 0;
			rec_summed = 0;
			fn_cur = 0;
			rec_cur = 0;
			rec_done = 0;
			locs_left = 0;
			skip_left = 0;
			failed = 0;
			predicted_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BIG_ENDIAN: be = cfg_data[0];
					REG_STACK_REG:  sreg = cfg_data;
					REG_PTR_BYTES:  pbytes = cfg_data[3:0];
					REG_TARGET_OK:  tgt = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) check_result();
		end
		pending = predicted_results.size();
	end

endmodule

@@ dv/testbench.sv @@
// Top of the stack map section parser bench: builds one long section of random
// records under changing register settings and idling, and gives the verdict.
// Depends on smsp_pkg, stack_map_section_parser and smsp_result_checker.
module testbench;
	import smsp_pkg::*;

	localparam int NUM_FNS = 8;
	localparam int QUIET_LIMIT = 20000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [7:0]   cfg_index = '0;
	logic [15:0]  cfg_data = '0;
	int           fail_count, pending;

	int           tx_idle_pct = 0;
	int           rx_stall_pct = 0;
	bit           hold_ask = 0;
	int           quiet_cycles = 0;

	logic         cur_be;
	logic [15:0]  cur_sreg;
	logic [3:0]   cur_ptr;
	logic [7:0]   section_bytes[$];
	int           sec_len = 0;
	int           last_at = -1;

	logic [63:0]  fn_addr[NUM_FNS];
	logic [63:0]  fn_frame[NUM_FNS];
	int           fn_recs[NUM_FNS];
	bit           fn_wide[NUM_FNS];

	stack_map_section_parser dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	smsp_result_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_cnt;
		bit hold_done;
		hold_cnt = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_ask && !hold_done) begin
				hold_cnt = 400;
				hold_done = 1;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready = 1'b0;
			end else begin
				m_tready = $urandom_range(99) >= rx_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** stack_map_section_parser: FAILED **");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
	endtask

	task automatic flush_bytes();
		foreach (section_bytes[i]) send_byte(section_bytes[i], i == last_at);
		section_bytes.delete();
		last_at = -1;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic quiesce();
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_regs(input logic be, input logic [15:0] sreg, input logic [3:0] ptr);
		quiesce();
		write_reg(REG_BIG_ENDIAN, {15'd0, be});
		write_reg(REG_STACK_REG, sreg);
		write_reg(REG_PTR_BYTES, {12'd0, ptr});
		cur_be = be;
		cur_sreg = sreg;
		cur_ptr = ptr;
	endtask

	task automatic put_field(input logic [63:0] v, input int w);
		for (int i = 0; i < w; i++) begin
			section_bytes.insert(section_bytes.size(),
				cur_be ? v[8 * (w - 1 - i) +: 8] : v[8 * i +: 8]);
			sec_len++;
		end
	endtask

	task automatic pad_to_eight();
		while (sec_len % 8 != 0) put_field(64'($urandom_range(255)), 1);
	endtask

	task automatic put_loc(input logic [7:0] kind, input logic [7:0] res8,
			input logic [15:0] size, input logic [15:0] regn, input logic [15:0] res16,
			input logic [31:0] off);
		put_field(64'(kind), 1);
		put_field(64'(res8), 1);
		put_field(64'(size), 2);
		put_field(64'(regn), 2);
		put_field(64'(res16), 2);
		put_field(64'(off), 4);
	endtask

	// sel: 0 upper bound, 1 lower bound, else random in range
	task automatic put_root(input logic [63:0] frame, input int sel);
		logic [31:0] off;
		bit huge;
		huge = frame > 64'hFFFF_FFFF;
		if (sel == 0) begin
			off = 32'd4096;
		end else if (sel == 1) begin
			off = huge ? 32'h8000_0000 : -(frame[31:0] + 32'd4096);
		end else if (huge) begin
			off = $urandom;
			if ($signed(off) > 4096) off = ~off;
		end else begin
			off = 32'd4096 - 32'($urandom_range(0, frame[31:0] + 8192));
		end
		put_loc(8'd3, 8'd0, {12'd0, cur_ptr}, cur_sreg, 16'd0, off);
	endtask

	task automatic put_other(input logic [7:0] kind);
		logic [15:0] size;
		size = $urandom_range(0, 65535);
		if (kind >= 8'd4 && $urandom_range(1)) size = {12'd0, cur_ptr};
		if (kind <= 8'd3 && size == {12'd0, cur_ptr}) size = size + 16'd1;
		put_loc(kind, 8'd0, size, 16'($urandom), 16'd0, $urandom);
	endtask

	// flaw: 0 none, 1 bad kind, 2 reserved set, 3 live-out padding set, 4 cut short
	task automatic gen_record(input int f, input bit directed, input int flaw);
		int n;
		int cnt;
		logic [31:0] ioff;
		ioff = fn_wide[f] ? $urandom : $urandom_range(0, 32'h7FFF_FFFF);
		n = directed ? 7 : $urandom_range(0, 4);
		put_field({$urandom, $urandom}, 8);
		put_field(64'(ioff), 4);
		put_field(64'd0, 2);
		put_field(64'(n + ((flaw == 1 || flaw == 2) ? 1 : 0)), 2);
		if (directed) begin
			put_root(fn_frame[f], 0);
			put_root(fn_frame[f], 1);
			for (int k = 1; k <= 5; k++) put_other(8'(k));
		end else begin
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1)) put_root(fn_frame[f], $urandom_range(0, 3));
				else put_other(8'($urandom_range(1, 5)));
			end
		end
		if (flaw == 1)
			put_loc($urandom_range(1) ? 8'd0 : 8'($urandom_range(6, 255)), 8'd0,
				16'd2, 16'd0, 16'd0, 32'd0);
		if (flaw == 2)
			put_loc(8'd4, 8'($urandom_range(1, 255)), 16'd2, 16'd0, 16'd0, 32'd0);
		pad_to_eight();
		put_field(flaw == 3 ? 64'($urandom_range(1, 65535)) : 64'd0, 2);
		cnt = directed ? 0 : $urandom_range(0, 3);
		put_field(64'(cnt), 2);
		for (int i = 0; i < cnt; i++) put_field(64'($urandom), 4);
		pad_to_eight();
		if (flaw == 4) last_at = $urandom_range(0, section_bytes.size() - 1);
	endtask

	initial begin
		int total_recs, consts, rec_no, flaw, trail, last_f;
		logic [3:0] ptr;
		logic [15:0] sreg;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_TARGET_OK, 16'd0);
		set_regs(1'b1, 16'hFFFF, 4'd4);

		// function table: the first function is narrow with a small frame
		total_recs = 0;
		last_f = 0;
		for (int f = 0; f < NUM_FNS; f++) begin
			fn_wide[f] = f != 0 && $urandom_range(3) == 0;
			fn_addr[f] = fn_wide[f] ? {1'b0, 31'($urandom), 32'($urandom)}
				: 64'($urandom_range(0, 32'h7FFF_FFFF));
			fn_frame[f] = (f != 0 && $urandom_range(3) == 0) ?
				64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(0, 4095)) :
				(f == 0 ? 64'h1000 : 64'($urandom_range(0, 65536)));
			fn_recs[f] = f == 0 ? 2 : $urandom_range(0, 5);
			total_recs += fn_recs[f];
			if (fn_recs[f] != 0) last_f = f;
		end
		consts = $urandom_range(0, 3);
		put_field(64'd3, 1);
		put_field(64'd0, 3);
		put_field(64'(NUM_FNS), 4);
		put_field(64'(consts), 4);
		put_field(64'(total_recs), 4);
		for (int f = 0; f < NUM_FNS; f++) begin
			put_field(fn_addr[f], 8);
			put_field(fn_frame[f], 8);
			put_field(64'(fn_recs[f]), 8);
		end
		for (int i = 0; i < consts; i++) put_field({$urandom, $urandom}, 8);
		// hold back the last byte before the record area until the target is enabled
		begin
			logic [7:0] final_b;
			final_b = section_bytes.pop_back();
			flush_bytes();
			quiesce();
			write_reg(REG_TARGET_OK, 16'd1);
			section_bytes.insert(section_bytes.size(), final_b);
			flush_bytes();
		end

		flaw = $urandom_range(0, 7);
		if (flaw < 4) flaw = 0;
		else flaw = flaw - 3;
		rec_no = 0;
		for (int f = 0; f < NUM_FNS; f++) begin
			for (int r = 0; r < fn_recs[f]; r++) begin
				if (rec_no != 0 && (rec_no % 3 == 0 || (fn_wide[f] && cur_ptr != 4'd8))) begin
					ptr = fn_wide[f] ? 4'd8 : 4'($urandom_range(4, 8));
					case ($urandom_range(3))
						0: sreg = 16'd0;
						1: sreg = 16'hFFFF;
						2: sreg = 16'd7;
						default: sreg = 16'($urandom);
					endcase
					set_regs(1'($urandom), sreg, ptr);
					case ((rec_no / 3) % 4)
						0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
						1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
						2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
						default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
					endcase
				end
				// the first record yields three results, enough to leave the result queue without room
				if (rec_no == 0) begin
					tx_idle_pct = 0;
					hold_ask = 1;
				end
				gen_record(f, rec_no == 0, (f == last_f && r == fn_recs[f] - 1) ? flaw : 0);
				flush_bytes();
				rec_no++;
			end
		end

		// trailing bytes after the record area, the final one flagged last
		trail = $urandom_range(0, 4);
		for (int i = 0; i <= trail; i++) put_field(64'($urandom_range(255)), 1);
		last_at = section_bytes.size() - 1;
		flush_bytes();

		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("** stack_map_section_parser: PASSED **");
		else
			$display("** stack_map_section_parser: FAILED **");
		$finish;
	end

endmodule
